### sv/ptds_pkg.sv
// shared types and constants for the poisson tile dart sampler
// used by ptds_dist, poisson_tile_dart_sampler and its testbench; no dependencies
`default_nettype none

package ptds_pkg;

   // default sizing of the point store and coordinate width
   localparam int MaxPointsDefault = 256;
   localparam int CoordBitsDefault = 16;

   // status code carried with every result
   typedef enum logic [1:0] {
      STATUS_REJECT   = 2'd0,
      STATUS_ACCEPT   = 2'd1,
      STATUS_NO_TRIES = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   // register index on the csr port, byte address is four times the index
   typedef enum logic [1:0] {
      REG_RADIUS    = 2'd0,
      REG_TILE_SIZE = 2'd1,
      REG_MAX_TRIES = 2'd2
   } reg_type;

   // tile shift applied to the stored point during one store walk
   typedef enum logic [2:0] {
      SHIFT_NONE,
      SHIFT_XNEG,
      SHIFT_XPOS,
      SHIFT_YNEG,
      SHIFT_YPOS
   } shift_type;

   // control into the distance unit
   typedef struct packed {
      logic      valid;
      shift_type shift;
   } dist_ctl_type;

   // status out of the distance unit
   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } dist_stat_type;

endpackage

`default_nettype wire

### sv/ptds_dist.sv
// pipelined squared-distance compare unit, one stored point per cycle
// depends on ptds_pkg for the shift code and control/status structs
`default_nettype none

module ptds_dist (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ptds_pkg::dist_ctl_type ctl,
   input  wire logic [15:0]            cand_x,
   input  wire logic [15:0]            cand_y,
   input  wire logic [15:0]            tile,
   input  wire logic [15:0]            pnt_x,
   input  wire logic [15:0]            pnt_y,
   input  wire logic [31:0]            r2,
   output ptds_pkg::dist_stat_type     stat
);
   import ptds_pkg::*;

   logic signed [17:0] tile_s;
   logic signed [17:0] sx;
   logic signed [17:0] sy;
   logic signed [17:0] dx;
   logic signed [17:0] dy;
   logic signed [35:0] dx_sq;
   logic signed [35:0] dy_sq;
   logic [34:0]        sqx_ff;
   logic [34:0]        sqy_ff;
   logic               va_ff;
   logic [35:0]        dist_sum;
   logic               hit_in;
   logic               hit_ff;
   logic               hv_ff;

   // shift of the stored point by one tile
   always_comb begin
      tile_s = signed'({2'b00, tile});
      sx = '0;
      sy = '0;
      case (ctl.shift)
         SHIFT_XNEG: sx = -tile_s;
         SHIFT_XPOS: sx = tile_s;
         SHIFT_YNEG: sy = -tile_s;
         SHIFT_YPOS: sy = tile_s;
         default: begin
            sx = '0;
            sy = '0;
         end
      endcase
   end

   // stage a: differences and squares
   assign dx    = signed'({2'b00, cand_x}) - signed'({2'b00, pnt_x}) - sx;
   assign dy    = signed'({2'b00, cand_y}) - signed'({2'b00, pnt_y}) - sy;
   assign dx_sq = 36'(dx) * 36'(dx);
   assign dy_sq = 36'(dy) * 36'(dy);

   // stage b: sum and compare against radius squared
   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign hit_in   = dist_sum <= {4'b0000, r2};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         hv_ff <= 1'b0;
      end else begin
         va_ff  <= ctl.valid;
         hv_ff  <= va_ff;
         sqx_ff <= dx_sq[34:0];
         sqy_ff <= dy_sq[34:0];
         hit_ff <= hit_in;
      end
   end

   assign stat.busy      = va_ff;
   assign stat.hit_valid = hv_ff;
   assign stat.hit       = hit_ff;

endmodule

`default_nettype wire

### sv/poisson_tile_dart_sampler.sv
// a candidate refused for tries or a full store gives its registered result in the cycle after start;
// a tested candidate walks the store of N points up to three times (direct, x shift, y shift),
// each walk reading the N points in turn and draining the distance pipeline; then 1 result or 4 results.
// refused candidates can start back to back; a tested one keeps busy high until its last
// result is registered, and start is ignored while busy.
// reset clears control, counters and configuration registers, not the point store; results cannot stall
`default_nettype none

module poisson_tile_dart_sampler #(
   parameter int MAX_POINTS = ptds_pkg::MaxPointsDefault,
   parameter int COORD_BITS = ptds_pkg::CoordBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // candidate channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_cand_x,
   input  wire logic [15:0] req_cand_y,
   // result channel
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_point_x,
   output logic [15:0]      rsp_point_y,
   output logic             rsp_last,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ptds_pkg::*;

   localparam int Cw   = COORD_BITS;
   localparam int AW   = $clog2(MAX_POINTS);
   localparam int CntW = $clog2(MAX_POINTS + 1);
   localparam logic [15:0] CoordMask =
      (COORD_BITS >= 16) ? 16'hFFFF : 16'((17'd1 << COORD_BITS) - 17'd1);

   typedef enum logic [1:0] {S_IDLE, S_CHECK, S_EMIT} state_type;
   typedef enum logic [1:0] {PASS_DIRECT, PASS_X, PASS_Y} pass_type;

   // control and registers
   state_type        state_ff, state_in;
   pass_type         pass_ff, pass_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  addr_ff, addr_in;
   logic [15:0]      tries_ff, tries_in;
   logic [15:0]      radius_ff, radius_in;
   logic [15:0]      tile_ff, tile_in;
   logic [15:0]      max_tries_ff, max_tries_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             bad_ff, bad_in;
   logic [1:0]       idx_ff, idx_in;
   logic             need_x_ff, need_x_in;
   logic             xneg_ff, xneg_in;
   logic             need_y_ff, need_y_in;
   logic             yneg_ff, yneg_in;
   logic [15:0]      x_ff, x_in;
   logic [15:0]      y_ff, y_in;
   logic [15:0]      t_ff, t_in;
   logic [31:0]      r2_ff, r2_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [15:0]      rsp_x_ff, rsp_x_in;
   logic [15:0]      rsp_y_ff, rsp_y_in;
   logic             rsp_last_ff, rsp_last_in;

   // point store
   logic [2*Cw-1:0]  store_mem [MAX_POINTS];
   logic [2*Cw-1:0]  rd_data_ff;
   logic [2*Cw-1:0]  wr_data;
   logic [CntW-1:0]  wr_addr;
   logic             mem_we;

   // datapath signals
   logic [15:0]      cand_xm, cand_ym, tile_m, cand_xc, cand_yc;
   logic             store_full;
   logic [15:0]      rot_x, rot_y;
   logic             bad_now;
   logic             csr_wr;
   reg_type          csr_idx;
   dist_ctl_type     dctl;
   dist_stat_type    dstat;

   // candidate masking and clamping
   assign cand_xm    = req_cand_x & CoordMask;
   assign cand_ym    = req_cand_y & CoordMask;
   assign tile_m     = tile_ff & CoordMask;
   assign cand_xc    = (cand_xm > tile_m) ? tile_m : cand_xm;
   assign cand_yc    = (cand_ym > tile_m) ? tile_m : cand_ym;
   assign store_full = count_ff > CntW'(MAX_POINTS - 4);

   // rotations about the tile center
   always_comb begin
      case (idx_ff)
         2'd0: begin
            rot_x = x_ff;
            rot_y = y_ff;
         end
         2'd1: begin
            rot_x = t_ff - y_ff;
            rot_y = x_ff;
         end
         2'd2: begin
            rot_x = t_ff - x_ff;
            rot_y = t_ff - y_ff;
         end
         default: begin
            rot_x = y_ff;
            rot_y = t_ff - x_ff;
         end
      endcase
   end

   assign wr_data = {Cw'(rot_y), Cw'(rot_x)};
   assign wr_addr = count_ff + CntW'(idx_ff);

   // distance unit fed from the registered store read
   always_comb begin
      dctl.valid = rd_valid_ff;
      case (pass_ff)
         PASS_X:  dctl.shift = xneg_ff ? SHIFT_XNEG : SHIFT_XPOS;
         PASS_Y:  dctl.shift = yneg_ff ? SHIFT_YNEG : SHIFT_YPOS;
         default: dctl.shift = SHIFT_NONE;
      endcase
   end

   ptds_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .ctl    (dctl),
      .cand_x (x_ff),
      .cand_y (y_ff),
      .tile   (t_ff),
      .pnt_x  (16'(rd_data_ff[Cw-1:0])),
      .pnt_y  (16'(rd_data_ff[2*Cw-1:Cw])),
      .r2     (r2_ff),
      .stat   (dstat)
   );

   assign bad_now = bad_ff | (dstat.hit_valid & dstat.hit);

   // register port
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = reg_type'(paddr[3:2]);
   assign pready  = 1'b1;

   always_comb begin
      unique case (csr_idx)
         REG_RADIUS:    prdata = {16'h0000, radius_ff};
         REG_TILE_SIZE: prdata = {16'h0000, tile_ff};
         REG_MAX_TRIES: prdata = {16'h0000, max_tries_ff};
         default:       prdata = '0;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      tries_in      = tries_ff;
      radius_in     = radius_ff;
      tile_in       = tile_ff;
      max_tries_in  = max_tries_ff;
      rd_valid_in   = 1'b0;
      bad_in        = bad_ff;
      idx_in        = idx_ff;
      need_x_in     = need_x_ff;
      xneg_in       = xneg_ff;
      need_y_in     = need_y_ff;
      yneg_in       = yneg_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      t_in          = t_ff;
      r2_in         = r2_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;

      // configuration writes
      if (csr_wr) begin
         unique case (csr_idx)
            REG_RADIUS:    radius_in    = pwdata[15:0];
            REG_TILE_SIZE: tile_in      = pwdata[15:0];
            REG_MAX_TRIES: max_tries_in = pwdata[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_x_in    = cand_xc;
               rsp_y_in    = cand_yc;
               rsp_last_in = 1'b1;
               if (tries_ff >= max_tries_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NO_TRIES;
               end else if (store_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FULL;
               end else begin
                  tries_in  = tries_ff + 16'd1;
                  x_in      = cand_xc;
                  y_in      = cand_yc;
                  t_in      = tile_m;
                  r2_in     = 32'(radius_ff) * 32'(radius_ff);
                  need_x_in = (cand_xc < radius_ff) ||
                              (({1'b0, cand_xc} + {1'b0, radius_ff}) > {1'b0, tile_m});
                  xneg_in   = cand_xc < radius_ff;
                  need_y_in = (cand_yc < radius_ff) ||
                              (({1'b0, cand_yc} + {1'b0, radius_ff}) > {1'b0, tile_m});
                  yneg_in   = cand_yc < radius_ff;
                  pass_in   = PASS_DIRECT;
                  addr_in   = '0;
                  bad_in    = 1'b0;
                  state_in  = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            bad_in = bad_now;
            if (addr_ff != count_ff) begin
               // issue the next store read
               rd_valid_in = 1'b1;
               addr_in     = addr_ff + CntW'(1);
            end else if (!rd_valid_ff && !dstat.busy) begin
               // walk finished and pipeline drained
               addr_in = '0;
               if (!bad_now && pass_ff == PASS_DIRECT && need_x_ff) begin
                  pass_in = PASS_X;
               end else if (!bad_now && pass_ff != PASS_Y && need_y_ff) begin
                  pass_in = PASS_Y;
               end else if (bad_now) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_REJECT;
                  rsp_x_in      = x_ff;
                  rsp_y_in      = y_ff;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  idx_in   = 2'd0;
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            // store and emit one rotation per cycle
            mem_we        = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_ACCEPT;
            rsp_x_in      = rot_x;
            rsp_y_in      = rot_y;
            rsp_last_in   = idx_ff == 2'd3;
            idx_in        = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               count_in = count_ff + CntW'(4);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer registers and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_DIRECT;
         count_ff     <= '0;
         addr_ff      <= '0;
         tries_ff     <= '0;
         radius_ff    <= '0;
         tile_ff      <= '0;
         max_tries_ff <= '0;
         rd_valid_ff  <= 1'b0;
         bad_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         count_ff      <= count_in;
         addr_ff       <= addr_in;
         tries_ff      <= tries_in;
         radius_ff     <= radius_in;
         tile_ff       <= tile_in;
         max_tries_ff  <= max_tries_in;
         rd_valid_ff   <= rd_valid_in;
         bad_ff        <= bad_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         need_x_ff     <= need_x_in;
         xneg_ff       <= xneg_in;
         need_y_ff     <= need_y_in;
         yneg_ff       <= yneg_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         t_ff          <= t_in;
         r2_ff         <= r2_in;
         rsp_status_ff <= rsp_status_in;
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // point store memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_addr[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= store_mem[addr_ff[AW-1:0]];
   end

   // outputs
   assign busy        = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_last    = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_ACCEPT |-> rsp_last)
      else $error("single result transaction without last");

   a_accept_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ACCEPT && !rsp_last |=>
         rsp_valid && rsp_status == STATUS_ACCEPT)
      else $error("accepted point burst broken");

   a_no_tries: assert property (@(posedge clock) disable iff (reset)
      start && !busy && tries_ff >= max_tries_ff |=>
         rsp_valid && rsp_status == STATUS_NO_TRIES && $stable(tries_ff))
      else $error("refused candidate not reported");

endmodule

`default_nettype wire
